/* rtl/mh64_pkg.sv */
// Shared constants and types for the MurmurHash64A stream hasher.
`default_nettype none
package mh64_pkg;

    // Hash constants
    localparam logic [63:0] MUR_M = 64'hc6a4a7935bd1e995;
    localparam int unsigned MUR_R = 47;

    // Field widths
    localparam int unsigned WORD_W      = 64;
    localparam int unsigned NBYTES_W    = 4;
    localparam int unsigned TLEN_W      = 32;
    localparam int unsigned BYTES_WORD  = 8;
    localparam int unsigned S_TDATA_W   = 104;
    localparam int unsigned LENGTH_BITS_DEF = 32;
    localparam int unsigned FIFO_DEPTH_DEF  = 2;

    // How a word touches the hash
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_TAIL = 2'd1,
        KIND_FULL = 2'd2
    } kind_t;

    // Classified request passed from front to back
    typedef struct packed {
        logic [63:0] word;
        kind_t       kind;
        logic        first;
        logic        last;
    } cmd_t;

    // Back-end sequencer states
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_LEN  = 6'b000010,
        ST_KA   = 6'b000100,
        ST_KB   = 6'b001000,
        ST_HM   = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    // Where the sequencer goes after a hash value is settled
    typedef struct packed {
        state_t      state;
        logic [63:0] op;
        logic [63:0] h;
    } step_t;

endpackage
`default_nettype wire

/* rtl/murmur64a_stream_hash.sv */
// Top level of the MurmurHash64A stream hasher.
`default_nettype none
// MurmurHash64A over a stream of 64-bit little-endian words. A front end takes each request,
// masks bytes past the valid count and queues it; a back end runs the hash on one shared
// 64x64 multiply-by-M unit. Each word is popped from the queue and then runs its products:
// a full word two key products and the hash product, a tail word the hash product, a word
// with no bytes none; a first word adds the length product and a last word finalization.
// The queue lets new requests in while the back end works, and the result register lets the
// next message run while a finished hash waits to be taken. The user must write the seed
// through seed_wr_en/seed_wr_data only while the block is idle; the block does not enforce it.
module murmur64a_stream_hash #(
    parameter int unsigned LENGTH_BITS = mh64_pkg::LENGTH_BITS_DEF,
    parameter int unsigned FIFO_DEPTH  = mh64_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           seed_wr_en,
    input  wire logic [63:0]                    seed_wr_data,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // data_word [63:0], valid_bytes [67:64], total_length [99:68], zero pad [103:100]
    input  wire logic [mh64_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // is_last
    input  wire logic                           s_axis_tlast,
    // is_first
    input  wire logic                           s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // hash_value [63:0]
    output logic [63:0]                         m_axis_tdata
);
    import mh64_pkg::*;

    localparam int unsigned LEN_W   = (LENGTH_BITS < TLEN_W) ? LENGTH_BITS : TLEN_W;
    localparam int unsigned CMD_W   = $bits(cmd_t);
    localparam int unsigned ENTRY_W = CMD_W + LEN_W;

    cmd_t               in_cmd;
    cmd_t               head_cmd;
    logic [LEN_W-1:0]   in_len;
    logic [LEN_W-1:0]   head_len;
    logic [ENTRY_W-1:0] head_vec;
    logic [63:0]        seed;
    logic               push;
    logic               pop;
    logic               fifo_full;
    logic               fifo_empty;

    // Accept and classify
    mh64_front #(
        .LEN_W (LEN_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .seed_wr_en   (seed_wr_en),
        .seed_wr_data (seed_wr_data),
        .s_valid      (s_axis_tvalid),
        .s_word       (s_axis_tdata[63:0]),
        .s_nbytes     (s_axis_tdata[67:64]),
        .s_first      (s_axis_tuser),
        .s_last       (s_axis_tlast),
        .s_len        (s_axis_tdata[99:68]),
        .fifo_full    (fifo_full),
        .s_ready      (s_axis_tready),
        .push         (push),
        .cmd          (in_cmd),
        .len          (in_len),
        .seed         (seed)
    );

    // Request queue
    mh64_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({in_len, in_cmd}),
        .pop       (pop),
        .head      (head_vec),
        .full      (fifo_full),
        .empty     (fifo_empty)
    );

    assign head_cmd = head_vec[CMD_W-1:0];
    assign head_len = head_vec[ENTRY_W-1:CMD_W];

    // Hash sequencer
    mh64_back #(
        .LEN_W (LEN_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (fifo_empty),
        .head_cmd   (head_cmd),
        .head_len   (head_len),
        .seed       (seed),
        .pop        (pop),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_hash     (m_axis_tdata)
    );

    // Back end only takes requests that are queued
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !fifo_empty)
        else $error("pop from empty request queue");

    // An accepted request is in the queue on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) push |=> !fifo_empty)
        else $error("accepted request lost from queue");

    // Queue never accepts while full
    assert property (@(posedge clk) disable iff (!rst_n) fifo_full |-> !push)
        else $error("queue overflow");

endmodule
`default_nettype wire

/* rtl/mh64_front.sv */
// Front end: seed register, request accept and word classification.
`default_nettype none
module mh64_front #(
    parameter int unsigned LEN_W = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 seed_wr_en,
    input  wire logic [63:0]          seed_wr_data,
    input  wire logic                 s_valid,
    input  wire logic [63:0]          s_word,
    input  wire logic [3:0]           s_nbytes,
    input  wire logic                 s_first,
    input  wire logic                 s_last,
    input  wire logic [31:0]          s_len,
    input  wire logic                 fifo_full,
    output logic                      s_ready,
    output logic                      push,
    output mh64_pkg::cmd_t            cmd,
    output logic [LEN_W-1:0]          len,
    output logic [63:0]               seed
);
    import mh64_pkg::*;

    logic [63:0] seed_reg;

    // Seed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (seed_wr_en)
        begin
            seed_reg <= seed_wr_data;
        end
    end

    assign seed    = seed_reg;
    assign s_ready = !fifo_full;
    assign push    = s_valid && !fifo_full;
    assign len     = s_len[LEN_W-1:0];

    // Classify and mask bytes past the valid count
    always_comb
    begin
        cmd.first = s_first;
        cmd.last  = s_last;
        if (s_nbytes >= NBYTES_W'(BYTES_WORD))
        begin
            cmd.kind = KIND_FULL;
        end
        else if (s_nbytes == '0)
        begin
            cmd.kind = KIND_NONE;
        end
        else
        begin
            cmd.kind = KIND_TAIL;
        end
        for (int i = 0; i < BYTES_WORD; i++)
        begin
            cmd.word[i*8 +: 8] = (NBYTES_W'(i) < s_nbytes) ? s_word[i*8 +: 8] : 8'h00;
        end
    end

endmodule
`default_nettype wire

/* rtl/mh64_fifo.sv */
// Small request queue between front and back end.
`default_nettype none
module mh64_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      head,
    output logic                  full,
    output logic                  empty
);
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

/* rtl/mh64_back.sv */
// Back end: hash sequencer around a shared two-stage multiply-by-M unit.
`default_nettype none
module mh64_back #(
    parameter int unsigned LEN_W = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             fifo_empty,
    input  wire mh64_pkg::cmd_t   head_cmd,
    input  wire logic [LEN_W-1:0] head_len,
    input  wire logic [63:0]      seed,
    output logic                  pop,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [63:0]           m_hash
);
    import mh64_pkg::*;

    state_t      state_reg, state_next;
    logic        ph_reg, ph_next;
    logic [63:0] op_reg, op_next;
    logic [63:0] h_reg, h_next;
    logic [63:0] word_reg, word_next;
    kind_t       kind_reg, kind_next;
    logic        last_reg, last_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_data_reg, out_data_next;

    logic [63:0] pp_ll_reg, pp_ll_next;
    logic [31:0] pp_lh_reg, pp_lh_next;
    logic [31:0] pp_hl_reg, pp_hl_next;
    logic [31:0] pp_mid;
    logic [63:0] mres;
    logic [63:0] mres_xs;
    step_t       stp;

    // Route after the hash value hv is known for the current word
    function automatic step_t body_step(input logic [63:0] hv, input kind_t kind,
                                        input logic [63:0] word, input logic last);
        step_t s;
        s.h     = hv;
        s.op    = hv ^ (hv >> MUR_R);
        s.state = last ? ST_FIN : ST_IDLE;
        unique case (kind)
            KIND_FULL:
            begin
                s.op    = word;
                s.state = ST_KA;
            end
            KIND_TAIL:
            begin
                s.h     = hv ^ word;
                s.op    = hv ^ word;
                s.state = ST_HM;
            end
            default:
            begin
                s.state = last ? ST_FIN : ST_IDLE;
            end
        endcase
        return s;
    endfunction

    // Multiply stage 1: partial products of op * M (low 64 bits only)
    always_comb
    begin
        pp_ll_next = 64'(op_reg[31:0]) * 64'(MUR_M[31:0]);
        pp_lh_next = op_reg[31:0] * MUR_M[63:32];
        pp_hl_next = op_reg[63:32] * MUR_M[31:0];
    end

    always_ff @(posedge clk)
    begin
        pp_ll_reg <= pp_ll_next;
        pp_lh_reg <= pp_lh_next;
        pp_hl_reg <= pp_hl_next;
    end

    // Multiply stage 2: combine partial products
    assign pp_mid  = pp_lh_reg + pp_hl_reg;
    assign mres    = pp_ll_reg + {pp_mid, 32'h0};
    assign mres_xs = mres ^ (mres >> MUR_R);

    // Sequencer: ph_reg marks the result cycle of each product
    always_comb
    begin
        state_next     = state_reg;
        ph_next        = ph_reg;
        op_next        = op_reg;
        h_next         = h_reg;
        word_next      = word_reg;
        kind_next      = kind_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        pop            = 1'b0;
        stp            = body_step(h_reg, head_cmd.kind, head_cmd.word, head_cmd.last);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!fifo_empty)
                begin
                    pop       = 1'b1;
                    word_next = head_cmd.word;
                    kind_next = head_cmd.kind;
                    last_next = head_cmd.last;
                    ph_next   = 1'b0;
                    if (head_cmd.first)
                    begin
                        op_next    = 64'(head_len);
                        state_next = ST_LEN;
                    end
                    else
                    begin
                        op_next    = stp.op;
                        h_next     = stp.h;
                        state_next = stp.state;
                    end
                end
            end
            ST_LEN:
            begin
                if (!ph_reg)
                begin
                    ph_next = 1'b1;
                end
                else
                begin
                    stp        = body_step(seed ^ mres, kind_reg, word_reg, last_reg);
                    op_next    = stp.op;
                    h_next     = stp.h;
                    state_next = stp.state;
                    ph_next    = 1'b0;
                end
            end
            ST_KA:
            begin
                if (!ph_reg)
                begin
                    ph_next = 1'b1;
                end
                else
                begin
                    op_next    = mres_xs;
                    state_next = ST_KB;
                    ph_next    = 1'b0;
                end
            end
            ST_KB:
            begin
                if (!ph_reg)
                begin
                    ph_next = 1'b1;
                end
                else
                begin
                    h_next     = h_reg ^ mres;
                    op_next    = h_reg ^ mres;
                    state_next = ST_HM;
                    ph_next    = 1'b0;
                end
            end
            ST_HM:
            begin
                if (!ph_reg)
                begin
                    ph_next = 1'b1;
                end
                else
                begin
                    h_next     = mres;
                    op_next    = mres_xs;
                    state_next = last_reg ? ST_FIN : ST_IDLE;
                    ph_next    = 1'b0;
                end
            end
            ST_FIN:
            begin
                if (!ph_reg)
                begin
                    ph_next = 1'b1;
                end
                else if (!out_valid_reg || m_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = mres_xs;
                    state_next     = ST_IDLE;
                    ph_next        = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                ph_next    = 1'b0;
            end
        endcase
    end

    // Control state and running hash
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ph_reg        <= 1'b0;
            h_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ph_reg        <= ph_next;
            h_reg         <= h_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        word_reg     <= word_next;
        kind_reg     <= kind_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_hash  = out_data_reg;

endmodule
`default_nettype wire
